### rtl/nps_pkg.sv
// Shared types and constants for the non-preemptive priority scheduler.
// Used by the controller, the datapath and the top level; depends on nothing.
package nps_pkg;

    localparam int MAX_JOBS   = 16;
    localparam int MAX_OWNERS = 16;
    localparam int IDX_W      = $clog2(MAX_JOBS);
    localparam int CNT_W      = $clog2(MAX_JOBS + 1);

    localparam int JOB_W   = 8;
    localparam int OWNER_W = 4;
    localparam int TIME_W  = 16;
    localparam int LEN_W   = 16;
    localparam int PRIO_W  = 8;

    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 48;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    typedef struct packed {
        logic [PRIO_W-1:0]  priority_level;
        logic [TIME_W-1:0]  arrival_time;
        logic [OWNER_W-1:0] owner_id;
        logic [JOB_W-1:0]   job_id;
        logic [LEN_W-1:0]   remaining;
    } slot_t;

    localparam int SLOT_W = $bits(slot_t);

    typedef struct packed {
        logic load;
        logic tick_start;
        logic scan_step;
        logic dispatch;
        logic finish;
    } ctl_cmd_t;

    typedef struct packed {
        logic busy;
        logic scan_last;
        logic out_free;
    } dp_sts_t;

endpackage

### rtl/nps_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module nps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/nps_ctrl.sv
// Sequencing state machine for the scheduler: load, table scan, run update, output.
// Depends on nps_pkg for the command and status structs.
module nps_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    input  logic             in_kind,
    output logic             s_tready,
    input  nps_pkg::dp_sts_t sts,
    output nps_pkg::ctl_cmd_t cmd
);
    import nps_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE     = 6'b000001,
        ST_SCAN     = 6'b000010,
        ST_SCAN_END = 6'b000100,
        ST_DISPATCH = 6'b001000,
        ST_RUN_RD   = 6'b010000,
        ST_RUN_EXE  = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (in_kind == KIND_LOAD) begin
                        cmd.load = 1'b1;
                    end else begin
                        cmd.tick_start = 1'b1;
                        state_next     = sts.busy ? ST_RUN_RD : ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                cmd.scan_step = 1'b1;
                if (sts.scan_last) begin
                    state_next = ST_SCAN_END;
                end
            end
            ST_SCAN_END: begin
                state_next = ST_DISPATCH;
            end
            ST_DISPATCH: begin
                cmd.dispatch = 1'b1;
                state_next   = ST_RUN_RD;
            end
            ST_RUN_RD: begin
                state_next = ST_RUN_EXE;
            end
            ST_RUN_EXE: begin
                if (sts.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

### rtl/nps_dp.sv
// Scheduler datapath: job table, valid bits, selection scan, run update, output word.
// Depends on nps_pkg and nps_ram.
module nps_dp (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  nps_pkg::ctl_cmd_t               cmd,
    output nps_pkg::dp_sts_t                sts,
    input  logic [nps_pkg::IN_DATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [nps_pkg::OUT_DATA_W-1:0]  m_tdata
);
    import nps_pkg::*;

    logic [MAX_JOBS-1:0] valid_reg;
    logic [IDX_W-1:0]    running_reg;
    logic                busy_reg;
    logic                idle_rep_reg;
    logic [TIME_W-1:0]   clock_reg;
    logic [CNT_W-1:0]    load_cnt_reg;
    logic                disp_reg;

    logic [IDX_W-1:0]    scan_idx_reg;
    logic                cand_vld_reg;
    logic [IDX_W-1:0]    cand_idx_reg;
    logic                found_reg;
    logic [IDX_W-1:0]    best_idx_reg;
    logic [PRIO_W-1:0]   best_prio_reg;
    logic [TIME_W-1:0]   best_arr_reg;

    logic                  out_vld_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;

    slot_t            rd_slot;
    slot_t            ld_slot;
    slot_t            up_slot;
    slot_t            wr_slot;
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [IDX_W-1:0] ram_raddr;
    logic [SLOT_W-1:0] ram_rdata;

    logic [OWNER_W-1:0] in_owner;
    logic [LEN_W-1:0]   in_len;
    logic               load_ok;

    logic              cand_ok;
    logic              cand_better;
    logic [LEN_W-1:0]  rem_dec;
    logic              cmpl;
    logic              idle_hit;
    logic [MAX_JOBS-1:0] valid_after;

    logic [TIME_W-1:0]  o_time;
    logic [JOB_W-1:0]   o_job;
    logic               o_cmpl;
    logic [OWNER_W-1:0] o_owner;
    logic [TIME_W-1:0]  o_finish;
    logic               o_all_done;

    // Input word unpacking and load normalization.
    assign in_owner = (32'(s_tdata[11:8]) >= MAX_OWNERS) ? OWNER_W'(MAX_OWNERS - 1)
                                                        : s_tdata[11:8];
    assign in_len   = (s_tdata[43:28] == '0) ? LEN_W'(1) : s_tdata[43:28];
    assign load_ok  = cmd.load && (load_cnt_reg < CNT_W'(MAX_JOBS));

    always_comb begin
        ld_slot.job_id         = s_tdata[7:0];
        ld_slot.owner_id       = in_owner;
        ld_slot.arrival_time   = s_tdata[27:12];
        ld_slot.remaining      = in_len;
        ld_slot.priority_level = s_tdata[51:44];
    end

    assign rd_slot = slot_t'(ram_rdata);

    // Run update of the current job.
    assign rem_dec = (rd_slot.remaining != '0) ? rd_slot.remaining - LEN_W'(1) : '0;
    assign cmpl    = busy_reg && (rem_dec == '0);

    always_comb begin
        up_slot           = rd_slot;
        up_slot.remaining = rem_dec;
    end

    assign ram_we    = load_ok || (cmd.finish && busy_reg);
    assign ram_waddr = load_ok ? load_cnt_reg[IDX_W-1:0] : running_reg;
    assign wr_slot   = load_ok ? ld_slot : up_slot;
    assign ram_raddr = cmd.scan_step ? scan_idx_reg : running_reg;

    nps_ram #(
        .WIDTH(SLOT_W),
        .DEPTH(MAX_JOBS)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (wr_slot),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Selection compare on the word read in the previous scan cycle.
    assign cand_ok = cand_vld_reg && valid_reg[cand_idx_reg]
                     && (rd_slot.arrival_time <= clock_reg);
    assign cand_better = !found_reg
                         || (rd_slot.priority_level < best_prio_reg)
                         || ((rd_slot.priority_level == best_prio_reg)
                             && (rd_slot.arrival_time < best_arr_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cand_vld_reg <= 1'b0;
            found_reg    <= 1'b0;
            scan_idx_reg <= '0;
        end else begin
            cand_vld_reg <= cmd.scan_step;
            if (cmd.tick_start) begin
                found_reg    <= 1'b0;
                scan_idx_reg <= '0;
            end else begin
                if (cmd.scan_step) begin
                    scan_idx_reg <= scan_idx_reg + IDX_W'(1);
                end
                if (cand_ok && cand_better) begin
                    found_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        cand_idx_reg <= scan_idx_reg;
        if (cand_ok && cand_better) begin
            best_idx_reg  <= cand_idx_reg;
            best_prio_reg <= rd_slot.priority_level;
            best_arr_reg  <= rd_slot.arrival_time;
        end
    end

    // Result of the tick being closed.
    assign idle_hit    = !busy_reg && (|valid_reg) && !idle_rep_reg;
    assign valid_after = cmpl ? (valid_reg & ~(MAX_JOBS'(1) << running_reg)) : valid_reg;

    assign o_time     = clock_reg;
    assign o_job      = busy_reg ? rd_slot.job_id : '0;
    assign o_cmpl     = cmpl;
    assign o_owner    = cmpl ? rd_slot.owner_id : '0;
    assign o_finish   = cmpl ? clock_reg + TIME_W'(1) : '0;
    assign o_all_done = ~(|valid_after);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            running_reg  <= '0;
            busy_reg     <= 1'b0;
            idle_rep_reg <= 1'b0;
            clock_reg    <= '0;
            load_cnt_reg <= '0;
            disp_reg     <= 1'b0;
        end else begin
            if (load_ok) begin
                valid_reg[load_cnt_reg[IDX_W-1:0]] <= 1'b1;
                load_cnt_reg <= load_cnt_reg + CNT_W'(1);
            end
            if (cmd.tick_start) begin
                disp_reg <= 1'b0;
            end
            if (cmd.dispatch && found_reg) begin
                running_reg  <= best_idx_reg;
                busy_reg     <= 1'b1;
                idle_rep_reg <= 1'b0;
                disp_reg     <= 1'b1;
            end
            if (cmd.finish) begin
                clock_reg <= clock_reg + TIME_W'(1);
                valid_reg <= valid_after;
                if (cmpl) begin
                    busy_reg <= 1'b0;
                end
                if (idle_hit) begin
                    idle_rep_reg <= 1'b1;
                end
            end
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (cmd.finish) begin
            out_vld_reg <= 1'b1;
        end else if (m_tready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            out_data_reg <= {o_all_done, o_finish, o_owner, o_cmpl, idle_hit,
                             disp_reg, o_job, o_time};
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

    assign sts.busy      = busy_reg;
    assign sts.scan_last = (scan_idx_reg == IDX_W'(MAX_JOBS - 1));
    assign sts.out_free  = !out_vld_reg || m_tready;

endmodule

### rtl/nonpreemptive_priority_scheduler.sv
// Non-preemptive priority scheduler top level: controller plus datapath.
// Depends on nps_pkg, nps_ctrl, nps_dp and nps_ram.
//
// The input channel carries load words (s_tuser = 0) that put a job into the
// next free slot of a 16-entry table, and tick words (s_tuser = 1) that
// advance simulated time by one step. A load gives no result; loads beyond
// the table size are dropped. Each tick gives exactly one result word on
// the output channel.
// A tick while a job runs goes through the run read and run execute states
// before its result is registered. A tick with no job running first scans
// all 16 table slots through the single read port of the table memory, one
// slot per cycle. s_tready is high only between items.
// The output register lets the block accept the next item while a result
// waits; if the receiver stalls, a following tick holds in its last step
// until the output register frees up, and nothing is lost.
// Reset (aresetn low, synchronous) empties the table, stops the running job,
// sets time to zero and drops any pending result.
module nonpreemptive_priority_scheduler (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // job_id[7:0], owner_id[11:8], arrival_time[27:12], run_length[43:28],
    // priority_level[51:44], zero padding[55:52]
    input  logic [nps_pkg::IN_DATA_W-1:0]   s_tdata,
    // kind[0]
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // time_now[15:0], run_job[23:16], dispatched[24], idle_start[25],
    // completed[26], done_owner[30:27], finish_time[46:31], all_done[47]
    output logic [nps_pkg::OUT_DATA_W-1:0]  m_tdata
);
    import nps_pkg::*;

    ctl_cmd_t cmd;
    dp_sts_t  sts;

    nps_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .in_kind  (s_tuser),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    nps_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

### rtl/nps_checker.sv
// Port-level checks for the scheduler top level, attached by a bind.
// Depends only on the top level's ports.
module nps_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("Stalled output word changed.");

    a_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[26] |-> m_tdata[46:31] == m_tdata[15:0] + 16'd1)
        else $error("Finish time is not the tick after the last service.");

    a_no_cmpl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[26] |-> m_tdata[46:31] == 16'd0 && m_tdata[30:27] == 4'd0)
        else $error("Completion fields set without a completion.");

    a_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[25] |-> !m_tdata[24] && !m_tdata[26] && !m_tdata[47])
        else $error("Idle start reported together with activity or no work.");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("Output word valid right after reset.");

endmodule

bind nonpreemptive_priority_scheduler nps_checker u_nps_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
